FILE: src/afp_pkg.sv
package afp_pkg;

  localparam int VMEM_DEPTH = 32768;
  localparam int VMEM_AW    = 15;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_MATRIX_A = 3'd0,
    REG_MATRIX_B = 3'd1,
    REG_MATRIX_C = 3'd2,
    REG_MATRIX_D = 3'd3,
    REG_CENTER_X = 3'd4,
    REG_CENTER_Y = 3'd5,
    REG_SCROLL   = 3'd6,
    REG_CONTROL  = 3'd7
  } reg_idx_t;

  // Control register bit positions
  localparam int CTL_HFLIP   = 0;
  localparam int CTL_VFLIP   = 1;
  localparam int CTL_EDGE_LO = 2;
  localparam int CTL_LAYER2  = 4;
  localparam int CTL_MAIN    = 5;
  localparam int CTL_SUB     = 6;
  localparam int CTL_PRIO0   = 7;
  localparam int CTL_PRIO1   = 11;

  // Edge modes; the two other codes wrap the plane
  localparam logic [1:0] EDGE_CLEAR = 2'd2;
  localparam logic [1:0] EDGE_TILE0 = 2'd3;

  typedef struct packed {
    logic [15:0] mat_a;
    logic [15:0] mat_b;
    logic [15:0] mat_c;
    logic [15:0] mat_d;
    logic [12:0] center_x;
    logic [12:0] center_y;
    logic [25:0] scroll;
    logic [14:0] ctrl;
  } cfg_t;

  // One transaction handed from the transform pipeline to the fetch unit
  typedef struct packed {
    logic        is_pix;
    logic [14:0] waddr;
    logic [7:0]  wbyte;
    logic [14:0] tile_addr;
    logic [5:0]  fine;
    logic        kill;
    logic        tile0;
  } fetch_req_t;

endpackage

FILE: src/affine_tilemap_pixel_fetch_top.sv
// Affine tilemap background pixel fetch.
// Input channel (in_valid / in_stall): each transaction is either a video
// memory write (in_req_type 0: in_mem_address, in_mem_byte) or a pixel
// (in_req_type 1: in_screen_x, in_screen_y). Writes return nothing; each
// pixel returns exactly one transaction on the output channel
// (out_valid / out_stall), in input order.
// Configuration: cfg_we writes cfg_data into register cfg_index at a rising
// edge; write only while no transaction is in flight.
// A pixel passes three transform stages, tile read and character read on
// its way to the output register. One write per cycle while not stalled;
// a pixel's two dependent reads hold the single video memory read port in
// turn, and the next transaction waits until the character read is issued.
// The next transaction is accepted while a finished result still waits.
// Reset clears configuration and pipeline control; video memory content is
// undefined until written and there is no clearing pass.
// A stalled output holds its result; backpressure fills the pipeline, then
// raises in_stall.
module affine_tilemap_pixel_fetch_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [25:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic [14:0] in_mem_address,
  input  logic [7:0]  in_mem_byte,
  input  logic [7:0]  in_screen_x,
  input  logic [7:0]  in_screen_y,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_color_index,
  output logic [3:0]  out_pixel_priority,
  output logic        out_main_hit,
  output logic        out_sub_hit
);

  afp_pkg::cfg_t       cfg_r;
  afp_pkg::fetch_req_t req;
  logic                req_valid;
  logic                req_take;

  // Configuration registers, reset to zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (afp_pkg::reg_idx_t'(cfg_index))
        afp_pkg::REG_MATRIX_A: cfg_r.mat_a    <= cfg_data[15:0];
        afp_pkg::REG_MATRIX_B: cfg_r.mat_b    <= cfg_data[15:0];
        afp_pkg::REG_MATRIX_C: cfg_r.mat_c    <= cfg_data[15:0];
        afp_pkg::REG_MATRIX_D: cfg_r.mat_d    <= cfg_data[15:0];
        afp_pkg::REG_CENTER_X: cfg_r.center_x <= cfg_data[12:0];
        afp_pkg::REG_CENTER_Y: cfg_r.center_y <= cfg_data[12:0];
        afp_pkg::REG_SCROLL:   cfg_r.scroll   <= cfg_data;
        afp_pkg::REG_CONTROL:  cfg_r.ctrl     <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // Flip, matrix products and sums; produces map address and edge decisions
  afp_xform u_xform (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_mem_address (in_mem_address),
    .in_mem_byte    (in_mem_byte),
    .in_screen_x    (in_screen_x),
    .in_screen_y    (in_screen_y),
    .req_valid      (req_valid),
    .req            (req),
    .req_take       (req_take)
  );

  // Video memory writes, tile and character reads, result register
  afp_fetch u_fetch (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .req_valid          (req_valid),
    .req                (req),
    .req_take           (req_take),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_color_index    (out_color_index),
    .out_pixel_priority (out_pixel_priority),
    .out_main_hit       (out_main_hit),
    .out_sub_hit        (out_sub_hit)
  );

endmodule

FILE: src/afp_ram.sv
module afp_ram #(
  parameter int W = 8,
  parameter int D = 32768
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic                 re,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/afp_xform.sv
module afp_xform (
  input  logic                clk,
  input  logic                rst_n,
  input  afp_pkg::cfg_t       cfg,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_req_type,
  input  logic [14:0]         in_mem_address,
  input  logic [7:0]          in_mem_byte,
  input  logic [7:0]          in_screen_x,
  input  logic [7:0]          in_screen_y,
  output logic                req_valid,
  output afp_pkg::fetch_req_t req,
  input  logic                req_take
);

  logic v1_r, v2_r, v3_r;
  logic free1, free2, free3;

  // stage 1: flipped screen coordinates
  logic        s1_pix_r;
  logic [14:0] s1_addr_r;
  logic [7:0]  s1_byte_r;
  logic [7:0]  s1_x_r;
  logic [7:0]  s1_y_r;

  // stage 2: partial products
  logic              s2_pix_r;
  logic [14:0]       s2_addr_r;
  logic [7:0]        s2_byte_r;
  logic signed [26:0] t_adx_r, t_bdy_r, t_cdx_r, t_ddy_r;
  logic signed [24:0] t_by_r, t_dy_r, p_ax_r, p_cx_r;

  afp_pkg::fetch_req_t s3_r, s3_nxt;

  logic signed [15:0] sa, sb, sc, sd;
  logic signed [13:0] diff_x, diff_y;
  logic signed [10:0] dx, dy;
  logic signed [8:0]  xs, ys;
  logic signed [26:0] p_adx, p_bdy, p_cdx, p_ddy;
  logic signed [24:0] p_by, p_dy, p_ax, p_cx;
  logic signed [28:0] sum_x, sum_y;
  logic               outside;
  logic [1:0]         edge_mode;

  assign free3    = !v3_r || req_take;
  assign free2    = !v2_r || free3;
  assign free1    = !v1_r || free2;
  assign in_stall = !free1;

  assign req_valid = v3_r;
  assign req       = s3_r;

  // dx/dy: scroll minus center, folded to a signed 11-bit offset
  always_comb begin
    sa = $signed(cfg.mat_a);
    sb = $signed(cfg.mat_b);
    sc = $signed(cfg.mat_c);
    sd = $signed(cfg.mat_d);
    diff_x = 14'($signed(cfg.scroll[12:0])) - 14'($signed(cfg.center_x));
    diff_y = 14'($signed(cfg.scroll[25:13])) - 14'($signed(cfg.center_y));
    dx = $signed({diff_x[13], diff_x[9:0]});
    dy = $signed({diff_y[13], diff_y[9:0]});
    xs = $signed({1'b0, s1_x_r});
    ys = $signed({1'b0, s1_y_r});
    p_adx = 27'(sa) * 27'(dx);
    p_bdy = 27'(sb) * 27'(dy);
    p_cdx = 27'(sc) * 27'(dx);
    p_ddy = 27'(sd) * 27'(dy);
    p_by  = 25'(sb) * 25'(ys);
    p_dy  = 25'(sd) * 25'(ys);
    p_ax  = 25'(sa) * 25'(xs);
    p_cx  = 25'(sc) * 25'(xs);
  end

  // plane coordinates in signed 21.8; integer part is sum[28:8]
  always_comb begin
    sum_x = 29'(t_adx_r) + 29'(t_bdy_r) + 29'(t_by_r) + 29'(p_ax_r)
          + 29'($signed({cfg.center_x, 8'd0}));
    sum_y = 29'(t_cdx_r) + 29'(t_ddy_r) + 29'(t_dy_r) + 29'(p_cx_r)
          + 29'($signed({cfg.center_y, 8'd0}));
    outside   = (|sum_x[28:18]) || (|sum_y[28:18]);
    edge_mode = cfg.ctrl[afp_pkg::CTL_EDGE_LO +: 2];
    s3_nxt.is_pix    = s2_pix_r;
    s3_nxt.waddr     = s2_addr_r;
    s3_nxt.wbyte     = s2_byte_r;
    s3_nxt.tile_addr = {sum_y[17:11], sum_x[17:11], 1'b0};
    s3_nxt.fine      = {sum_y[10:8], sum_x[10:8]};
    s3_nxt.kill      = outside && (edge_mode == afp_pkg::EDGE_CLEAR);
    s3_nxt.tile0     = outside && (edge_mode == afp_pkg::EDGE_TILE0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (free1) v1_r <= in_valid;
      if (free2) v2_r <= v1_r;
      if (free3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (free1) begin
      s1_pix_r  <= in_req_type;
      s1_addr_r <= in_mem_address;
      s1_byte_r <= in_mem_byte;
      s1_x_r    <= cfg.ctrl[afp_pkg::CTL_HFLIP] ? ~in_screen_x : in_screen_x;
      s1_y_r    <= cfg.ctrl[afp_pkg::CTL_VFLIP] ? ~in_screen_y : in_screen_y;
    end
    if (free2) begin
      s2_pix_r  <= s1_pix_r;
      s2_addr_r <= s1_addr_r;
      s2_byte_r <= s1_byte_r;
      // drop the low 6 bits of the offset and y partial products
      t_adx_r   <= $signed({p_adx[26:6], 6'd0});
      t_bdy_r   <= $signed({p_bdy[26:6], 6'd0});
      t_cdx_r   <= $signed({p_cdx[26:6], 6'd0});
      t_ddy_r   <= $signed({p_ddy[26:6], 6'd0});
      t_by_r    <= $signed({p_by[24:6], 6'd0});
      t_dy_r    <= $signed({p_dy[24:6], 6'd0});
      p_ax_r    <= p_ax;
      p_cx_r    <= p_cx;
    end
    if (free3) begin
      s3_r <= s3_nxt;
    end
  end

endmodule

FILE: src/afp_fetch.sv
module afp_fetch (
  input  logic                clk,
  input  logic                rst_n,
  input  afp_pkg::cfg_t       cfg,
  input  logic                req_valid,
  input  afp_pkg::fetch_req_t req,
  output logic                req_take,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_color_index,
  output logic [3:0]          out_pixel_priority,
  output logic                out_main_hit,
  output logic                out_sub_hit
);

  logic       b_v_r, b_tile0_r, b_kill_r;
  logic [5:0] b_fine_r;
  logic       c_v_r, c_kill_r;
  logic       out_v_r;

  logic       c_done, c_block, b_go, a_go;
  logic       ram_we, ram_re;
  logic [afp_pkg::VMEM_AW-1:0] ram_raddr;
  logic [7:0] ram_rdata;
  logic [7:0] tile;
  logic [7:0] col_raw, col;
  logic [3:0] prio;
  logic       layer2;

  afp_ram #(
    .W(8),
    .D(afp_pkg::VMEM_DEPTH)
  ) u_vmem (
    .clk   (clk),
    .we    (ram_we),
    .waddr (req.waddr),
    .wdata (req.wbyte),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // C holds the color byte in the RAM output until the result register frees
  assign c_done  = c_v_r && (!out_v_r || !out_stall);
  assign c_block = c_v_r && !c_done;
  assign b_go    = b_v_r && !c_block;
  assign a_go    = req_valid && !b_v_r && (!req.is_pix || !c_block);
  assign req_take = a_go;

  assign tile      = b_tile0_r ? 8'd0 : ram_rdata;
  assign ram_we    = a_go && !req.is_pix;
  assign ram_re    = b_go || (a_go && req.is_pix);
  assign ram_raddr = b_go ? {tile, b_fine_r, 1'b1} : req.tile_addr;

  always_comb begin
    layer2  = cfg.ctrl[afp_pkg::CTL_LAYER2];
    col_raw = c_kill_r ? 8'd0 : ram_rdata;
    prio    = cfg.ctrl[afp_pkg::CTL_PRIO0 +: 4];
    col     = col_raw;
    if (layer2) begin
      if (col_raw[7]) prio = cfg.ctrl[afp_pkg::CTL_PRIO1 +: 4];
      col = {1'b0, col_raw[6:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r   <= 1'b0;
      c_v_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (a_go && req.is_pix) begin
        b_v_r <= 1'b1;
      end else if (b_go) begin
        b_v_r <= 1'b0;
      end
      if (b_go) begin
        c_v_r <= 1'b1;
      end else if (c_done) begin
        c_v_r <= 1'b0;
      end
      out_v_r <= c_done || (out_v_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (a_go) begin
      b_tile0_r <= req.tile0;
      b_kill_r  <= req.kill;
      b_fine_r  <= req.fine;
    end
    if (b_go) begin
      c_kill_r <= b_kill_r;
    end
    if (c_done) begin
      if (col == 8'd0) begin
        out_color_index    <= 8'd0;
        out_pixel_priority <= 4'd0;
        out_main_hit       <= 1'b0;
        out_sub_hit        <= 1'b0;
      end else begin
        out_color_index    <= col;
        out_pixel_priority <= prio;
        out_main_hit       <= cfg.ctrl[afp_pkg::CTL_MAIN];
        out_sub_hit        <= cfg.ctrl[afp_pkg::CTL_SUB];
      end
    end
  end

  assign out_valid = out_v_r;

endmodule

FILE: dv/affine_fetch_monitor.sv
`timescale 1ns / 100ps

module affine_fetch_monitor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [25:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_req_type,
  input  logic [14:0] in_mem_address,
  input  logic [7:0]  in_mem_byte,
  input  logic [7:0]  in_screen_x,
  input  logic [7:0]  in_screen_y,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_color_index,
  input  logic [3:0]  out_pixel_priority,
  input  logic        out_main_hit,
  input  logic        out_sub_hit,
  output int          pending_results,
  output int          mismatch_count
);

  typedef struct packed {
    logic [7:0] color;
    logic [3:0] prio;
    logic       main_hit;
    logic       sub_hit;
  } pixel_result_t;

  logic [7:0]     vmem [afp_pkg::VMEM_DEPTH];
  afp_pkg::cfg_t  regs;
  pixel_result_t  expected_pixels [$];
  pixel_result_t  want, got;

  // Difference of two 13-bit values folded to the 10-bit plane, sign from bit 13
  function automatic int wrap_diff(input int n);
    logic [31:0] u;
    u = n;
    if (u[13]) return $signed({22'h3FFFFF, u[9:0]});
    return $signed({22'd0, u[9:0]});
  endfunction

  // Partial product with the low 6 bits dropped
  function automatic logic [31:0] clip6(input int p);
    logic [31:0] u;
    u = p;
    return u & 32'hFFFF_FFC0;
  endfunction

  function automatic logic [31:0] shift8(input logic [31:0] v);
    logic signed [31:0] s;
    s = v;
    return s >>> 8;
  endfunction

  function automatic pixel_result_t render_pixel(input logic [7:0] sx, input logic [7:0] sy);
    int            a, b, c, d, cx, cy, ho, vo, x, y, dx, dy;
    logic [31:0]   psx, psy, px, py, addr;
    logic [7:0]    tile, color;
    logic [3:0]    prio;
    logic [1:0]    edge_mode;
    logic          outside;
    pixel_result_t r;
    a  = $signed(regs.mat_a);
    b  = $signed(regs.mat_b);
    c  = $signed(regs.mat_c);
    d  = $signed(regs.mat_d);
    cx = $signed(regs.center_x);
    cy = $signed(regs.center_y);
    ho = $signed(regs.scroll[12:0]);
    vo = $signed(regs.scroll[25:13]);
    x  = sx;
    y  = sy;
    if (regs.ctrl[afp_pkg::CTL_HFLIP]) x = 255 - x;
    if (regs.ctrl[afp_pkg::CTL_VFLIP]) y = 255 - y;
    dx  = wrap_diff(ho - cx);
    dy  = wrap_diff(vo - cy);
    psx = clip6(a * dx) + clip6(b * dy) + clip6(b * y) + cx * 256;
    psy = clip6(c * dx) + clip6(d * dy) + clip6(d * y) + cy * 256;
    px  = shift8(psx + a * x);
    py  = shift8(psy + c * x);
    edge_mode = regs.ctrl[afp_pkg::CTL_EDGE_LO +: 2];
    outside   = |((px | py) & 32'hFFFF_FC00);
    if (edge_mode == afp_pkg::EDGE_CLEAR && outside) begin
      color = 8'd0;
    end else begin
      tile = 8'd0;
      if (!(edge_mode == afp_pkg::EDGE_TILE0 && outside)) begin
        px   = px & 32'd1023;
        py   = py & 32'd1023;
        addr = ((py >> 3) * 128 + (px >> 3)) << 1;
        tile = vmem[addr[14:0]];
      end
      addr  = ((({24'd0, tile} << 6) + ((py & 32'd7) << 3) + (px & 32'd7)) << 1) + 32'd1;
      color = vmem[addr[14:0]];
    end
    prio = regs.ctrl[afp_pkg::CTL_PRIO0 +: 4];
    if (regs.ctrl[afp_pkg::CTL_LAYER2]) begin
      if (color[7]) prio = regs.ctrl[afp_pkg::CTL_PRIO1 +: 4];
      color[7] = 1'b0;
    end
    if (color == 8'd0) begin
      r = '0;
    end else begin
      r = {color, prio, regs.ctrl[afp_pkg::CTL_MAIN], regs.ctrl[afp_pkg::CTL_SUB]};
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      regs = '0;
      expected_pixels.delete();
      pending_results = 0;
      mismatch_count  = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          afp_pkg::REG_MATRIX_A: regs.mat_a    = cfg_data[15:0];
          afp_pkg::REG_MATRIX_B: regs.mat_b    = cfg_data[15:0];
          afp_pkg::REG_MATRIX_C: regs.mat_c    = cfg_data[15:0];
          afp_pkg::REG_MATRIX_D: regs.mat_d    = cfg_data[15:0];
          afp_pkg::REG_CENTER_X: regs.center_x = cfg_data[12:0];
          afp_pkg::REG_CENTER_Y: regs.center_y = cfg_data[12:0];
          afp_pkg::REG_SCROLL:   regs.scroll   = cfg_data[25:0];
          afp_pkg::REG_CONTROL:  regs.ctrl     = cfg_data[14:0];
          default: ;
        endcase
      end
      // retire the oldest pixel before taking a new transaction this edge
      if (out_valid && !out_stall) begin
        got = {out_color_index, out_pixel_priority, out_main_hit, out_sub_hit};
        if (expected_pixels.size() == 0) begin
          mismatch_count++;
          $display("%0t: expected no result, actual color %0d prio %0d main %0b sub %0b",
                   $time, got.color, got.prio, got.main_hit, got.sub_hit);
        end else begin
          want = expected_pixels.pop_front();
          if (got != want) begin
            mismatch_count++;
            if (got.color != want.color)
              $display("%0t: color_index expected %0d actual %0d",
                       $time, want.color, got.color);
            if (got.prio != want.prio)
              $display("%0t: pixel_priority expected %0d actual %0d",
                       $time, want.prio, got.prio);
            if (got.main_hit != want.main_hit)
              $display("%0t: main_hit expected %0b actual %0b",
                       $time, want.main_hit, got.main_hit);
            if (got.sub_hit != want.sub_hit)
              $display("%0t: sub_hit expected %0b actual %0b",
                       $time, want.sub_hit, got.sub_hit);
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (in_req_type) expected_pixels.push_back(render_pixel(in_screen_x, in_screen_y));
        else vmem[in_mem_address] = in_mem_byte;
      end
      pending_results = expected_pixels.size();
    end
  end

endmodule

FILE: dv/affine_tilemap_pixel_fetch_top_tb.sv
`timescale 1ns / 100ps

module affine_tilemap_pixel_fetch_top_tb;

  // Cycles with no transaction on any port before the run is declared hung
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_PHASES  = 12;
  localparam int PHASE_ITEMS    = 50;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [25:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic        in_req_type;
  logic [14:0] in_mem_address;
  logic [7:0]  in_mem_byte;
  logic [7:0]  in_screen_x;
  logic [7:0]  in_screen_y;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_color_index;
  logic [3:0]  out_pixel_priority;
  logic        out_main_hit;
  logic        out_sub_hit;
  int          pending_results;
  int          mismatch_count;

  // Register image written as one group at every reconfiguration
  logic [25:0] cfg_vals [8];

  // Image of what has been sent to video memory; a pixel only goes out once
  // every byte it reads has been written
  logic [7:0]  vmem_img [afp_pkg::VMEM_DEPTH];
  bit          vmem_set [afp_pkg::VMEM_DEPTH];

  // Probe pixels; the first three land on the hand-written map and character bytes
  logic [7:0]  probe_x [5] = '{8'd0, 8'd1, 8'd2, 8'd255, 8'd128};
  logic [7:0]  probe_y [5] = '{8'd0, 8'd0, 8'd0, 8'd255, 8'd64};

  int burst_left   = 0;
  int n_writes     = 0;
  int n_fills      = 0;
  int n_pixels     = 0;
  int n_settings   = 0;
  int quiet_cycles = 0;
  int stall_mode   = 0;
  int stall_span   = 0;
  int stall_tick   = 0;
  int phase_end    = 0;

  affine_tilemap_pixel_fetch_top uut (.*);

  affine_fetch_monitor monitor (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver: switch between free running, light, heavy and periodic stalls
  always @(negedge clk) begin
    if (stall_span == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_span = $urandom_range(20, 300);
    end
    stall_span--;
    stall_tick++;
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= ((stall_tick % 7) < 3);
    endcase
  end

  // Watchdog: end the run when the ports go quiet for too long
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired, %0d results outstanding", $time, pending_results);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Character bytes with zero (transparent) weighted up
  function automatic logic [7:0] char_byte();
    if ($urandom_range(0, 7) == 0) return 8'd0;
    return 8'($urandom);
  endfunction

  // Map bytes favor a handful of tiles so character bytes get reused
  function automatic logic [7:0] fill_tile();
    if ($urandom_range(0, 3) == 0) return 8'($urandom);
    return 8'($urandom_range(0, 7));
  endfunction

  function automatic logic [15:0] matrix_value();
    int v;
    case ($urandom_range(0, 3))
      0: v = $urandom_range(0, 512);
      1: v = 256 + $urandom_range(0, 128) - 64;
      2: v = $urandom;
      default: begin
        case ($urandom_range(0, 2))
          0:       v = 16'h7FFF;
          1:       v = 16'h8000;
          default: v = 0;
        endcase
      end
    endcase
    if ($urandom_range(0, 1)) v = -v;
    return 16'(v);
  endfunction

  function automatic int wrap_diff(input int n);
    logic [31:0] u;
    u = n;
    if (u[13]) return $signed({22'h3FFFFF, u[9:0]});
    return $signed({22'd0, u[9:0]});
  endfunction

  function automatic logic [31:0] clip6(input int p);
    logic [31:0] u;
    u = p;
    return u & 32'hFFFF_FFC0;
  endfunction

  function automatic logic [31:0] shift8(input logic [31:0] v);
    logic signed [31:0] s;
    s = v;
    return s >>> 8;
  endfunction

  // Which video memory bytes a pixel reads under the current register image:
  // the map byte, and the character byte at {tile, fine, 1}
  task automatic pixel_reads(input logic [7:0] sx, input logic [7:0] sy,
                             output logic rd_map, output logic rd_char,
                             output logic [14:0] map_addr, output logic [5:0] fine);
    int          a, b, c, d, cx, cy, ho, vo, x, y, dx, dy;
    logic [31:0] px, py;
    logic [14:0] ctrl;
    logic [1:0]  edge_mode;
    logic        outside;
    a    = $signed(cfg_vals[afp_pkg::REG_MATRIX_A][15:0]);
    b    = $signed(cfg_vals[afp_pkg::REG_MATRIX_B][15:0]);
    c    = $signed(cfg_vals[afp_pkg::REG_MATRIX_C][15:0]);
    d    = $signed(cfg_vals[afp_pkg::REG_MATRIX_D][15:0]);
    cx   = $signed(cfg_vals[afp_pkg::REG_CENTER_X][12:0]);
    cy   = $signed(cfg_vals[afp_pkg::REG_CENTER_Y][12:0]);
    ho   = $signed(cfg_vals[afp_pkg::REG_SCROLL][12:0]);
    vo   = $signed(cfg_vals[afp_pkg::REG_SCROLL][25:13]);
    ctrl = cfg_vals[afp_pkg::REG_CONTROL][14:0];
    x    = sx;
    y    = sy;
    if (ctrl[afp_pkg::CTL_HFLIP]) x = 255 - x;
    if (ctrl[afp_pkg::CTL_VFLIP]) y = 255 - y;
    dx = wrap_diff(ho - cx);
    dy = wrap_diff(vo - cy);
    px = shift8(clip6(a * dx) + clip6(b * dy) + clip6(b * y) + cx * 256 + a * x);
    py = shift8(clip6(c * dx) + clip6(d * dy) + clip6(d * y) + cy * 256 + c * x);
    edge_mode = ctrl[afp_pkg::CTL_EDGE_LO +: 2];
    outside   = |((px | py) & 32'hFFFF_FC00);
    rd_char   = !(edge_mode == afp_pkg::EDGE_CLEAR && outside);
    rd_map    = rd_char && !(edge_mode == afp_pkg::EDGE_TILE0 && outside);
    map_addr  = {py[9:3], px[9:3], 1'b0};
    fine      = {py[2:0], px[2:0]};
  endtask

  // Drive one transaction at a falling edge and hold it until accepted.
  // Open a new burst after a gap when the current burst is spent.
  task automatic send_item(input logic rt, input logic [14:0] addr, input logic [7:0] data,
                           input logic [7:0] sx, input logic [7:0] sy);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 250)
                                               : $urandom_range(1, 24);
    end
    in_valid       <= 1'b1;
    in_req_type    <= rt;
    in_mem_address <= addr;
    in_mem_byte    <= data;
    in_screen_x    <= sx;
    in_screen_y    <= sy;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    burst_left--;
    if (rt) n_pixels++;
    else n_writes++;
  endtask

  task automatic send_write(input logic [14:0] addr, input logic [7:0] data);
    vmem_img[addr] = data;
    vmem_set[addr] = 1'b1;
    send_item(1'b0, addr, data, 8'($urandom), 8'($urandom));
  endtask

  // Write whatever map and character byte the pixel would read unwritten,
  // then send the pixel
  task automatic send_pixel(input logic [7:0] sx, input logic [7:0] sy);
    logic        rd_map, rd_char;
    logic [14:0] map_addr, char_addr;
    logic [5:0]  fine;
    pixel_reads(sx, sy, rd_map, rd_char, map_addr, fine);
    if (rd_map && !vmem_set[map_addr]) begin
      send_write(map_addr, fill_tile());
      n_fills++;
    end
    char_addr = {(rd_map ? vmem_img[map_addr] : 8'd0), fine, 1'b1};
    if (rd_char && !vmem_set[char_addr]) begin
      send_write(char_addr, char_byte());
      n_fills++;
    end
    send_item(1'b1, 15'($urandom), 8'($urandom), sx, sy);
  endtask

  // Drop valid, drain every pending pixel, let trailing writes settle,
  // then load the whole register image.
  task automatic reconfigure();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_results != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= afp_pkg::reg_idx_t'(i);
      cfg_data  <= cfg_vals[i];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    burst_left = 0;
    n_settings++;
  endtask

  task automatic send_probes();
    for (int i = 0; i < 5; i++) send_pixel(probe_x[i], probe_y[i]);
  endtask

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = afp_pkg::REG_MATRIX_A;
    cfg_data       = '0;
    in_valid       = 1'b0;
    in_req_type    = 1'b0;
    in_mem_address = '0;
    in_mem_byte    = '0;
    in_screen_x    = '0;
    in_screen_y    = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Map entry 0 points at tile 1; its first three pixels are
    // transparent, bit 7 only, and all ones.
    send_write(15'd0, 8'd1);
    send_write(15'd129, 8'h00);
    send_write(15'd131, 8'h80);
    send_write(15'd133, 8'hFF);

    // Identity transform, first layer, both screens
    cfg_vals[afp_pkg::REG_MATRIX_A] = 26'h0100;
    cfg_vals[afp_pkg::REG_MATRIX_B] = 26'h0000;
    cfg_vals[afp_pkg::REG_MATRIX_C] = 26'h0000;
    cfg_vals[afp_pkg::REG_MATRIX_D] = 26'h0100;
    cfg_vals[afp_pkg::REG_CENTER_X] = 26'h0000;
    cfg_vals[afp_pkg::REG_CENTER_Y] = 26'h0000;
    cfg_vals[afp_pkg::REG_SCROLL]   = 26'h0000;
    cfg_vals[afp_pkg::REG_CONTROL]  = (26'd1 << afp_pkg::CTL_MAIN) |
                                      (26'd1 << afp_pkg::CTL_SUB) |
                                      (26'd5 << afp_pkg::CTL_PRIO0) |
                                      (26'd10 << afp_pkg::CTL_PRIO1);
    reconfigure();
    send_probes();

    // Second layer, main screen only: bit 7 alone turns transparent
    cfg_vals[afp_pkg::REG_CONTROL] = (26'd1 << afp_pkg::CTL_LAYER2) |
                                     (26'd1 << afp_pkg::CTL_MAIN) |
                                     (26'd3 << afp_pkg::CTL_PRIO0) |
                                     (26'd12 << afp_pkg::CTL_PRIO1);
    reconfigure();
    send_probes();

    // Extreme matrix, center and scroll; clear outside the plane
    cfg_vals[afp_pkg::REG_MATRIX_A] = 26'h7FFF;
    cfg_vals[afp_pkg::REG_MATRIX_B] = 26'h8000;
    cfg_vals[afp_pkg::REG_MATRIX_C] = 26'h8000;
    cfg_vals[afp_pkg::REG_MATRIX_D] = 26'h7FFF;
    cfg_vals[afp_pkg::REG_CENTER_X] = 26'h1000;
    cfg_vals[afp_pkg::REG_CENTER_Y] = 26'h0FFF;
    cfg_vals[afp_pkg::REG_SCROLL]   = {13'h0FFF, 13'h1000};
    cfg_vals[afp_pkg::REG_CONTROL]  = (26'(afp_pkg::EDGE_CLEAR) << afp_pkg::CTL_EDGE_LO) |
                                      (26'd1 << afp_pkg::CTL_MAIN) |
                                      (26'd1 << afp_pkg::CTL_SUB) |
                                      (26'd15 << afp_pkg::CTL_PRIO0);
    reconfigure();
    send_probes();

    // Negative scale, every control bit set: tile 0 outside the plane, both flips
    cfg_vals[afp_pkg::REG_MATRIX_A] = 26'h8000;
    cfg_vals[afp_pkg::REG_MATRIX_B] = 26'h0000;
    cfg_vals[afp_pkg::REG_MATRIX_C] = 26'h0000;
    cfg_vals[afp_pkg::REG_MATRIX_D] = 26'h8000;
    cfg_vals[afp_pkg::REG_CENTER_X] = 26'h0FFF;
    cfg_vals[afp_pkg::REG_CENTER_Y] = 26'h1000;
    cfg_vals[afp_pkg::REG_SCROLL]   = 26'h3FFFFFF;
    cfg_vals[afp_pkg::REG_CONTROL]  = 26'h7FFF;
    reconfigure();
    send_probes();

    // Random register settings, mostly pixels with writes mixed in
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      for (int i = 0; i < 4; i++) cfg_vals[i] = {10'($urandom), matrix_value()};
      cfg_vals[afp_pkg::REG_CENTER_X] = 26'($urandom);
      cfg_vals[afp_pkg::REG_CENTER_Y] = 26'($urandom);
      cfg_vals[afp_pkg::REG_SCROLL]   = 26'($urandom);
      cfg_vals[afp_pkg::REG_CONTROL]  = 26'($urandom);
      reconfigure();
      phase_end = n_writes + n_pixels + PHASE_ITEMS;
      while (n_writes + n_pixels < phase_end) begin
        if ($urandom_range(0, 9) < 7) send_pixel(8'($urandom), 8'($urandom));
        else send_write(15'($urandom), char_byte());
      end
    end

    // Drain and give the pipeline time to show any stray result
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_results != 0) @(negedge clk);
    repeat (12) @(negedge clk);

    $display("run: %0d memory writes (%0d placed ahead of a pixel), %0d pixels",
             n_writes, n_fills, n_pixels);
    $display("run: %0d register settings incl. edge modes, flips, layers, extremes", n_settings);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
